>>> hdl/absds_pkg.sv
// Shared types and constants for the absolute-difference statistics block.
`timescale 1ns / 1ps
package absds_pkg;

  localparam int DIFF_W   = 16;
  localparam int POS_W    = 8;
  localparam int DIM_W    = 9;
  localparam int COUNT_W  = 17;
  localparam int SUM_W    = 33;
  localparam int SQSUM_W  = 49;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int CALC_W   = 64;
  localparam int STEP_W   = 6;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd64;

  // Configuration register indexes
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_ACC,
    ST_CALC,
    ST_EMIT
  } top_state_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_MEAN_ADD,
    CS_MEAN_DIV,
    CS_MUL_P,
    CS_MUL_Q,
    CS_SUB,
    CS_DEC,
    CS_MUL_D,
    CS_VAR_DIV,
    CS_SQRT,
    CS_DONE
  } calc_state_t;

  typedef struct packed {
    logic [DIFF_W-1:0] mean;
    logic [DIFF_W-1:0] std;
    logic              few;
  } calc_res_t;

endpackage

>>> hdl/absds_calc.sv
// Final statistics pass: mean, variance and square root on one shared adder.
`timescale 1ns / 1ps
module absds_calc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [absds_pkg::COUNT_W-1:0]  n,
  input  logic [absds_pkg::SUM_W-1:0]    s1,
  input  logic [absds_pkg::SQSUM_W-1:0]  s2,
  output logic                           done,
  output absds_pkg::calc_res_t           res
);
  import absds_pkg::*;

  localparam logic [CALC_W-1:0] SQRT_TOP_BIT = CALC_W'(1) << (CALC_W - 2);

  calc_state_t       state_r, state_nxt;
  logic [CALC_W-1:0] acc_r, acc_nxt;
  logic [CALC_W-1:0] opa_r, opa_nxt;
  logic [CALC_W-1:0] opb_r, opb_nxt;
  logic [CALC_W-1:0] p_r, p_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIFF_W-1:0] mean_r, mean_nxt;
  logic [DIFF_W-1:0] std_r, std_nxt;
  logic              few_r, few_nxt;

  logic [CALC_W-1:0] alu_a, alu_b;
  logic              alu_sub;
  logic [CALC_W:0]   alu_res;
  logic              no_borrow;
  logic [CALC_W-1:0] mul_acc, div_rem, div_q, sqrt_res;
  logic              last_step;

  function automatic logic [DIFF_W-1:0] sat16(input logic [CALC_W-1:0] v);
    sat16 = (|v[CALC_W-1:DIFF_W]) ? {DIFF_W{1'b1}} : v[DIFF_W-1:0];
  endfunction

  // Shared add / subtract unit
  assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + {{CALC_W{1'b0}}, alu_sub};
  assign no_borrow = alu_res[CALC_W];

  assign mul_acc   = opb_r[0] ? alu_res[CALC_W-1:0] : acc_r;
  assign div_rem   = no_borrow ? alu_res[CALC_W-1:0] : alu_a;
  assign div_q     = {opb_r[CALC_W-2:0], no_borrow};
  assign sqrt_res  = no_borrow ? ((opa_r >> 1) | opb_r) : (opa_r >> 1);
  assign last_step = (cnt_r == '0);

  always_comb begin
    alu_a   = acc_r;
    alu_b   = opa_r;
    alu_sub = 1'b0;
    case (state_r)
      CS_MEAN_ADD: begin
        alu_a = CALC_W'(s1);
        alu_b = CALC_W'(n >> 1);
      end
      CS_MEAN_DIV, CS_VAR_DIV: begin
        alu_a   = {acc_r[CALC_W-2:0], opb_r[CALC_W-1]};
        alu_sub = 1'b1;
      end
      CS_SUB: begin
        alu_a   = p_r;
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      CS_DEC: begin
        alu_a   = CALC_W'(n);
        alu_b   = CALC_W'(1);
        alu_sub = 1'b1;
      end
      CS_SQRT: begin
        alu_b   = opa_r | opb_r;
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE:     if (start) state_nxt = CS_MEAN_ADD;
      CS_MEAN_ADD: state_nxt = CS_MEAN_DIV;
      CS_MEAN_DIV: if (last_step) state_nxt = few_r ? CS_DONE : CS_MUL_P;
      CS_MUL_P:    if (last_step) state_nxt = CS_MUL_Q;
      CS_MUL_Q:    if (last_step) state_nxt = CS_SUB;
      CS_SUB:      state_nxt = CS_DEC;
      CS_DEC:      state_nxt = CS_MUL_D;
      CS_MUL_D:    if (last_step) state_nxt = CS_VAR_DIV;
      CS_VAR_DIV:  if (last_step) state_nxt = CS_SQRT;
      CS_SQRT:     if (last_step) state_nxt = CS_DONE;
      CS_DONE:     state_nxt = CS_IDLE;
      default:     state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r - STEP_W'(1);
    mean_nxt = mean_r;
    std_nxt  = std_r;
    few_nxt  = few_r;
    case (state_r)
      CS_MEAN_ADD: begin
        // dividend is sum plus half the count, so the quotient rounds halves up
        opb_nxt = alu_res[CALC_W-1:0];
        opa_nxt = CALC_W'(n);
        acc_nxt = '0;
        cnt_nxt = '1;
        few_nxt = (n <= COUNT_W'(1));
      end
      CS_MEAN_DIV: begin
        acc_nxt = div_rem;
        opb_nxt = div_q;
        if (last_step) begin
          mean_nxt = sat16(div_q);
          std_nxt  = '0;
          acc_nxt  = '0;
          opa_nxt  = CALC_W'(s2);
          opb_nxt  = CALC_W'(n);
          cnt_nxt  = STEP_W'(COUNT_W - 1);
        end
      end
      CS_MUL_P, CS_MUL_Q, CS_MUL_D: begin
        acc_nxt = mul_acc;
        opa_nxt = opa_r << 1;
        opb_nxt = opb_r >> 1;
        if (last_step) begin
          case (state_r)
            CS_MUL_P: begin
              p_nxt   = mul_acc;
              acc_nxt = '0;
              opa_nxt = CALC_W'(s1);
              opb_nxt = CALC_W'(s1);
              cnt_nxt = STEP_W'(SUM_W - 1);
            end
            CS_MUL_D: begin
              // divide N*S2 - S1^2 by N*(N-1)
              opa_nxt = mul_acc;
              opb_nxt = p_r;
              acc_nxt = '0;
              cnt_nxt = '1;
            end
            default: ;
          endcase
        end
      end
      CS_SUB: begin
        p_nxt = alu_res[CALC_W-1:0];
      end
      CS_DEC: begin
        opb_nxt = alu_res[CALC_W-1:0];
        opa_nxt = CALC_W'(n);
        acc_nxt = '0;
        cnt_nxt = STEP_W'(COUNT_W - 1);
      end
      CS_VAR_DIV: begin
        acc_nxt = div_rem;
        opb_nxt = div_q;
        if (last_step) begin
          acc_nxt = div_q;
          opa_nxt = '0;
          opb_nxt = SQRT_TOP_BIT;
          cnt_nxt = STEP_W'(CALC_W / 2 - 1);
        end
      end
      CS_SQRT: begin
        if (no_borrow) acc_nxt = alu_res[CALC_W-1:0];
        opa_nxt = sqrt_res;
        opb_nxt = opb_r >> 2;
        if (last_step) std_nxt = sat16(sqrt_res);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    p_r    <= p_nxt;
    cnt_r  <= cnt_nxt;
    mean_r <= mean_nxt;
    std_r  <= std_nxt;
    few_r  <= few_nxt;
  end

  assign done     = (state_r == CS_DONE);
  assign res.mean = mean_r;
  assign res.std  = std_r;
  assign res.few  = few_r;

endmodule

>>> hdl/abs_difference_statistics_unit.sv
// Absolute-difference statistics over a streamed pair of sample fields.
//
// Input channel (in_valid/in_ready): one live/canonical sample pair per
// transfer, column-major, with in_last_element on the final pair.
// Result channel (out_valid/out_ready): one transfer per field pair, carrying
// min, max, rounded mean, sample standard deviation and location of the max.
// Configuration channel (cfg_valid/cfg_ready): index 0 row count, index 1
// column count; always ready, write only while the block is idle.
// Each pair goes through accept, the min/max/square step and the accumulate in
// turn, with the single 16x16 square registered before the accumulate takes it.
// The last pair adds the statistics pass on one shared 64-bit add/subtract
// unit: a 64-step mean division, three shift-add multiplies (17, 33, 17
// steps), a 64-step variance division and a 32-step square root; the pass
// ends after the mean division when the field has at most one element.
// in_ready is low while a pair or the pass is at work.
// A finished result waits in the output register while the next field
// streams in; only the next result waits for out_ready.
// Reset clears the accumulators, drops out_valid and sets both dimensions
// to 64.
`timescale 1ns / 1ps
module abs_difference_statistics_unit #(
  parameter int MAX_DIM     = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_live_value,
  input  logic [SAMPLE_BITS-1:0]        in_canonical_value,
  input  logic                          in_last_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [absds_pkg::DIFF_W-1:0]  out_diff_min,
  output logic [absds_pkg::DIFF_W-1:0]  out_diff_max,
  output logic [absds_pkg::DIFF_W-1:0]  out_diff_mean,
  output logic [absds_pkg::DIFF_W-1:0]  out_diff_std,
  output logic [absds_pkg::POS_W-1:0]   out_max_row,
  output logic [absds_pkg::POS_W-1:0]   out_max_column,
  output logic                          out_too_few_elements,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [absds_pkg::DIM_W-1:0]   cfg_wdata
);
  import absds_pkg::*;

  localparam int SD_W = SAMPLE_BITS + 1;
  localparam int AD_W = (SD_W > DIFF_W + 1) ? SD_W : DIFF_W + 1;
  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'((MAX_DIM < 256) ? MAX_DIM : 256);

  top_state_t          state_r, state_nxt;
  logic [DIM_W-1:0]    row_count_r, row_count_nxt;
  logic [DIM_W-1:0]    column_count_r, column_count_nxt;
  logic [DIFF_W-1:0]   diff_r, diff_nxt;
  logic                last_r, last_nxt;
  logic [SQ_W-1:0]     sq_r, sq_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [DIFF_W-1:0]   min_r, min_nxt;
  logic [DIFF_W-1:0]   max_r, max_nxt;
  logic [POS_W-1:0]    max_row_r, max_row_nxt;
  logic [POS_W-1:0]    max_col_r, max_col_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQSUM_W-1:0]  sqsum_r, sqsum_nxt;
  logic [POS_W-1:0]    row_pos_r, row_pos_nxt;
  logic [POS_W-1:0]    col_pos_r, col_pos_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DIFF_W-1:0]   out_min_r, out_min_nxt;
  logic [DIFF_W-1:0]   out_max_r, out_max_nxt;
  logic [DIFF_W-1:0]   out_mean_r, out_mean_nxt;
  logic [DIFF_W-1:0]   out_std_r, out_std_nxt;
  logic [POS_W-1:0]    out_row_r, out_row_nxt;
  logic [POS_W-1:0]    out_col_r, out_col_nxt;
  logic                out_few_r, out_few_nxt;

  logic signed [SD_W-1:0] sample_diff;
  logic [SD_W-1:0]     abs_diff;
  logic [AD_W-1:0]     abs_wide;
  logic [DIFF_W-1:0]   diff_sat;
  logic [DIM_W-1:0]    rows_eff, cols_eff;
  logic [DIM_W-1:0]    pre_row, pre_col, post_row, post_col;
  logic                calc_start, calc_done, emit_go;
  calc_res_t           calc_res;

  // Saturated absolute difference of the incoming pair
  assign sample_diff = $signed({in_live_value[SAMPLE_BITS-1], in_live_value})
                       - $signed({in_canonical_value[SAMPLE_BITS-1], in_canonical_value});
  assign abs_diff    = sample_diff[SD_W-1] ? (~sample_diff + SD_W'(1)) : sample_diff;
  assign abs_wide    = AD_W'(abs_diff);
  assign diff_sat    = (|abs_wide[AD_W-1:DIFF_W]) ? {DIFF_W{1'b1}} : abs_wide[DIFF_W-1:0];

  assign rows_eff = (row_count_r == '0) ? DIM_W'(1)
                  : (row_count_r > DIM_LIMIT) ? DIM_LIMIT : row_count_r;
  assign cols_eff = (column_count_r == '0) ? DIM_W'(1)
                  : (column_count_r > DIM_LIMIT) ? DIM_LIMIT : column_count_r;

  // Position of this element (wrap a stale position first) and of the next one
  always_comb begin
    pre_row = DIM_W'(row_pos_r);
    pre_col = DIM_W'(col_pos_r);
    if (pre_row >= rows_eff) begin
      pre_row = '0;
      pre_col = pre_col + DIM_W'(1);
    end
    if (pre_col >= cols_eff) pre_col = '0;
    post_row = pre_row + DIM_W'(1);
    post_col = pre_col;
    if (post_row >= rows_eff) begin
      post_row = '0;
      post_col = pre_col + DIM_W'(1);
      if (post_col >= cols_eff) post_col = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_r ? ST_CALC : ST_IDLE;
      ST_CALC: if (calc_done) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    calc_start = (state_r == ST_ACC) && last_r;
    emit_go    = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    row_count_nxt    = row_count_r;
    column_count_nxt = column_count_r;
    diff_nxt         = diff_r;
    last_nxt         = last_r;
    sq_nxt           = sq_r;
    count_nxt        = count_r;
    min_nxt          = min_r;
    max_nxt          = max_r;
    max_row_nxt      = max_row_r;
    max_col_nxt      = max_col_r;
    sum_nxt          = sum_r;
    sqsum_nxt        = sqsum_r;
    row_pos_nxt      = row_pos_r;
    col_pos_nxt      = col_pos_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_min_nxt      = out_min_r;
    out_max_nxt      = out_max_r;
    out_mean_nxt     = out_mean_r;
    out_std_nxt      = out_std_r;
    out_row_nxt      = out_row_r;
    out_col_nxt      = out_col_r;
    out_few_nxt      = out_few_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count_nxt = cfg_wdata;
        REG_COLUMN_COUNT: column_count_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          diff_nxt = diff_sat;
          last_nxt = in_last_element;
        end
      end
      ST_STEP: begin
        sq_nxt = {{DIFF_W{1'b0}}, diff_r} * {{DIFF_W{1'b0}}, diff_r};
        if (diff_r < min_r) min_nxt = diff_r;
        if ((count_r == '0) || (diff_r > max_r)) begin
          max_nxt     = diff_r;
          max_row_nxt = pre_row[POS_W-1:0];
          max_col_nxt = pre_col[POS_W-1:0];
        end
        row_pos_nxt = post_row[POS_W-1:0];
        col_pos_nxt = post_col[POS_W-1:0];
      end
      ST_ACC: begin
        // hold count and sums once the count reaches its cap
        if (!count_r[COUNT_W-1]) begin
          count_nxt = count_r + COUNT_W'(1);
          sum_nxt   = sum_r + SUM_W'(diff_r);
          sqsum_nxt = sqsum_r + SQSUM_W'(sq_r);
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = min_r;
          out_max_nxt   = max_r;
          out_mean_nxt  = calc_res.mean;
          out_std_nxt   = calc_res.std;
          out_row_nxt   = max_row_r;
          out_col_nxt   = max_col_r;
          out_few_nxt   = calc_res.few;
          count_nxt     = '0;
          min_nxt       = '1;
          max_nxt       = '0;
          max_row_nxt   = '0;
          max_col_nxt   = '0;
          sum_nxt       = '0;
          sqsum_nxt     = '0;
          row_pos_nxt   = '0;
          col_pos_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      row_count_r    <= DIM_RESET;
      column_count_r <= DIM_RESET;
      count_r        <= '0;
      min_r          <= '1;
      max_r          <= '0;
      max_row_r      <= '0;
      max_col_r      <= '0;
      sum_r          <= '0;
      sqsum_r        <= '0;
      row_pos_r      <= '0;
      col_pos_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      row_count_r    <= row_count_nxt;
      column_count_r <= column_count_nxt;
      count_r        <= count_nxt;
      min_r          <= min_nxt;
      max_r          <= max_nxt;
      max_row_r      <= max_row_nxt;
      max_col_r      <= max_col_nxt;
      sum_r          <= sum_nxt;
      sqsum_r        <= sqsum_nxt;
      row_pos_r      <= row_pos_nxt;
      col_pos_r      <= col_pos_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    diff_r     <= diff_nxt;
    last_r     <= last_nxt;
    sq_r       <= sq_nxt;
    out_min_r  <= out_min_nxt;
    out_max_r  <= out_max_nxt;
    out_mean_r <= out_mean_nxt;
    out_std_r  <= out_std_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_few_r  <= out_few_nxt;
  end

  absds_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_start),
    .n     (count_r),
    .s1    (sum_r),
    .s2    (sqsum_r),
    .done  (calc_done),
    .res   (calc_res)
  );

  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_diff_min         = out_min_r;
  assign out_diff_max         = out_max_r;
  assign out_diff_mean        = out_mean_r;
  assign out_diff_std         = out_std_r;
  assign out_max_row          = out_row_r;
  assign out_max_column       = out_col_r;
  assign out_too_few_elements = out_few_r;

endmodule

>>> hdl/absds_checker.sv
// Port-level checks for the absolute-difference statistics block, with its bind.
`timescale 1ns / 1ps
module absds_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [absds_pkg::DIFF_W-1:0]  out_diff_min,
  input logic [absds_pkg::DIFF_W-1:0]  out_diff_max,
  input logic [absds_pkg::DIFF_W-1:0]  out_diff_mean,
  input logic [absds_pkg::DIFF_W-1:0]  out_diff_std,
  input logic                          out_too_few_elements
);
  import absds_pkg::*;

  // A stalled result keeps its statistics
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_diff_min)
      && $stable(out_diff_max) && $stable(out_diff_mean) && $stable(out_diff_std))
    else $error("result changed while stalled");

  a_few_std: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_few_elements |-> out_diff_std == '0)
    else $error("single-element result with nonzero std");

  // Rounded mean lies between min and max
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_diff_min <= out_diff_mean) && (out_diff_mean <= out_diff_max))
    else $error("mean outside min/max");

  // An accepted pair drops in_ready while the block works on it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after a transfer");

  a_reset_drop: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind abs_difference_statistics_unit absds_checker u_absds_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_diff_min         (out_diff_min),
  .out_diff_max         (out_diff_max),
  .out_diff_mean        (out_diff_mean),
  .out_diff_std         (out_diff_std),
  .out_too_few_elements (out_too_few_elements)
);
